>>> sv/isw_pkg.sv
// Package of the interval subtraction sweep: widths, codes, queue entry and helpers.
package isw_pkg;

  localparam int unsigned COORD_BITS  = 32;
  localparam int unsigned INDEX_BITS  = 16;
  localparam int unsigned TAG_BITS    = 32;
  // Queue depth must stay a power of two: the pointers wrap by overflow.
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_BITS   = $clog2(QUEUE_DEPTH);

  typedef logic [COORD_BITS-1:0] coord_t;
  typedef logic [INDEX_BITS-1:0] index_t;
  typedef logic [TAG_BITS-1:0]   tag_t;
  typedef logic [QPTR_BITS-1:0]  qptr_t;
  typedef logic [QPTR_BITS:0]    qcount_t;

  typedef enum logic {
    OP_QUERY   = 1'b0,
    OP_OVERLAP = 1'b1
  } opcode_e;

  // Work for the back end: an optional gap piece followed by an optional remainder.
  typedef struct packed {
    logic   gap_v;
    coord_t gap_lo;
    coord_t gap_hi;
    index_t gap_idx;
    logic   rem_v;
    coord_t rem_lo;
    coord_t rem_hi;
    index_t rem_idx;
    tag_t   tag;
  } work_t;

  function automatic index_t sat_inc(index_t v, logic en);
    index_t r;
    r = v;
    if (en && (v != '1)) begin
      r = v + index_t'(1);
    end
    return r;
  endfunction

endpackage

>>> sv/isw_if.sv
// Stream interfaces of the sweep: query/overlap items in, uncovered pieces out.
interface isw_item_if;
  logic                valid;
  logic                ready;
  logic                opcode;
  isw_pkg::coord_t     iv_lo;
  isw_pkg::coord_t     iv_hi;
  isw_pkg::tag_t       query_tag;
  logic                is_final;

  modport source (output valid, output opcode, output iv_lo, output iv_hi,
                  output query_tag, output is_final, input ready);
  modport sink   (input valid, input opcode, input iv_lo, input iv_hi,
                  input query_tag, input is_final, output ready);
endinterface

interface isw_piece_if;
  logic                valid;
  logic                ready;
  isw_pkg::coord_t     piece_lo;
  isw_pkg::coord_t     piece_hi;
  isw_pkg::tag_t       piece_tag;
  isw_pkg::index_t     piece_index;
  logic                piece_closing;

  modport source (output valid, output piece_lo, output piece_hi, output piece_tag,
                  output piece_index, output piece_closing, input ready);
  modport sink   (input valid, input piece_lo, input piece_hi, input piece_tag,
                  input piece_index, input piece_closing, output ready);
endinterface

>>> sv/interval_subtract_sweep.sv
// Top level of the interval subtraction sweep: front end, work queue and back end.
//
//   Channel   Dir  Beat contents
//   item_i    in   opcode, iv_lo, iv_hi, query_tag, is_final
//   piece_o   out  piece_lo, piece_hi, piece_tag, piece_index, piece_closing
//
// The front end takes one item beat per cycle whenever the two-entry work queue
// has room; all classification (gap clip, cursor advance, remainder) is done in
// that cycle. The back end emits one piece beat per cycle, while piece_o is
// ready, from its output register, so an item that yields both a gap and a
// remainder holds the back end for both beats while the queue takes new items.
// Reset clears the sweep state, the queue pointers and the output valid; no
// query is open afterwards. A stalled piece_o only stops the front once the
// queue has filled.
//
// The front end holds the cursor, the query end, the query tag, the saturating
// piece counter and the open flag. Each queued entry carries at most two pieces,
// already numbered, so the back end never looks at sweep state.
module interval_subtract_sweep (
  input  logic        clk_i,
  input  logic        rst_ni,
  isw_item_if.sink    item_i,
  isw_piece_if.source piece_o
);

  logic           q_push_v, q_push_rdy;
  isw_pkg::work_t q_push_data;
  logic           q_pop_v, q_pop_rdy;
  isw_pkg::work_t q_pop_data;

  isw_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_i       (item_i),
    .push_valid_o (q_push_v),
    .push_ready_i (q_push_rdy),
    .push_data_o  (q_push_data)
  );

  isw_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (q_push_v),
    .push_ready_o (q_push_rdy),
    .push_data_i  (q_push_data),
    .pop_valid_o  (q_pop_v),
    .pop_ready_i  (q_pop_rdy),
    .pop_data_o   (q_pop_data)
  );

  isw_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (q_pop_v),
    .pop_ready_o (q_pop_rdy),
    .pop_data_i  (q_pop_data),
    .piece_o     (piece_o)
  );

  // Every emitted piece is non-empty.
  a_piece_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    piece_o.valid |-> (piece_o.piece_lo < piece_o.piece_hi))
    else $error("empty piece emitted");

  // Only work that yields at least one piece is ever queued.
  a_queue_has_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_v |-> (q_pop_data.gap_v || q_pop_data.rem_v))
    else $error("queued entry carries no piece");

  // A completed push leaves the queue non-empty in the next cycle.
  a_push_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_push_v && q_push_rdy) |=> q_pop_v)
    else $error("pushed work lost");

endmodule

>>> sv/isw_front.sv
// Front end: accepts items, keeps the sweep state and classifies each item into work.
module isw_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  isw_item_if.sink          item_i,
  output logic              push_valid_o,
  input  logic              push_ready_i,
  output isw_pkg::work_t    push_data_o
);

  isw_pkg::coord_t cursor_q, cursor_d;
  isw_pkg::coord_t limit_q, limit_d;
  isw_pkg::tag_t   ident_q, ident_d;
  isw_pkg::index_t count_q, count_d;
  logic            open_q, open_d;

  logic            accept;
  logic            handled;
  isw_pkg::coord_t gap_end;
  isw_pkg::coord_t new_cur;
  isw_pkg::work_t  work;

  assign item_i.ready = push_ready_i;
  assign accept       = item_i.valid && push_ready_i;

  always_comb begin
    cursor_d = cursor_q;
    limit_d  = limit_q;
    ident_d  = ident_q;
    count_d  = count_q;
    open_d   = open_q;
    work     = '0;
    handled  = 1'b0;
    gap_end  = (item_i.iv_lo < limit_q) ? item_i.iv_lo : limit_q;
    new_cur  = (item_i.iv_hi < limit_q) ? item_i.iv_hi : limit_q;

    if (item_i.opcode == isw_pkg::OP_QUERY) begin
      handled  = 1'b1;
      cursor_d = item_i.iv_lo;
      limit_d  = item_i.iv_hi;
      ident_d  = item_i.query_tag;
      count_d  = '0;
      open_d   = 1'b1;
    end else if (open_q) begin
      handled      = 1'b1;
      work.gap_v   = gap_end > cursor_q;
      work.gap_lo  = cursor_q;
      work.gap_hi  = gap_end;
      if (new_cur > cursor_q) begin
        cursor_d = new_cur;
      end
    end

    work.gap_idx = count_d;
    work.rem_idx = isw_pkg::sat_inc(count_d, work.gap_v);
    work.tag     = ident_d;
    work.rem_lo  = cursor_d;
    work.rem_hi  = limit_d;

    if (handled && item_i.is_final) begin
      work.rem_v = cursor_d < limit_d;
      cursor_d   = limit_d;
      open_d     = 1'b0;
    end

    count_d = isw_pkg::sat_inc(work.rem_idx, work.rem_v);
  end

  assign push_valid_o = accept && (work.gap_v || work.rem_v);
  assign push_data_o  = work;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cursor_q <= '0;
      limit_q  <= '0;
      ident_q  <= '0;
      count_q  <= '0;
      open_q   <= 1'b0;
    end else if (accept) begin
      cursor_q <= cursor_d;
      limit_q  <= limit_d;
      ident_q  <= ident_d;
      count_q  <= count_d;
      open_q   <= open_d;
    end
  end

endmodule

>>> sv/isw_queue.sv
// Short work queue between the front and back ends.
module isw_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_valid_i,
  output logic              push_ready_o,
  input  isw_pkg::work_t    push_data_i,
  output logic              pop_valid_o,
  input  logic              pop_ready_i,
  output isw_pkg::work_t    pop_data_o
);

  isw_pkg::work_t   entry_q [isw_pkg::QUEUE_DEPTH];
  isw_pkg::qptr_t   wr_ptr_q, rd_ptr_q;
  isw_pkg::qcount_t count_q;
  logic             do_push, do_pop;

  assign push_ready_o = count_q != isw_pkg::qcount_t'(isw_pkg::QUEUE_DEPTH);
  assign pop_valid_o  = count_q != '0;
  assign pop_data_o   = entry_q[rd_ptr_q];
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + isw_pkg::qptr_t'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + isw_pkg::qptr_t'(1);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + isw_pkg::qcount_t'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - isw_pkg::qcount_t'(1);
      end
    end
  end

endmodule

>>> sv/isw_back.sv
// Back end: turns queued work into one or two piece beats through an output register.
module isw_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              pop_valid_i,
  output logic              pop_ready_o,
  input  isw_pkg::work_t    pop_data_i,
  isw_piece_if.source       piece_o
);

  logic            out_v_q, out_v_d;
  isw_pkg::coord_t out_lo_q, out_lo_d;
  isw_pkg::coord_t out_hi_q, out_hi_d;
  isw_pkg::tag_t   out_tag_q, out_tag_d;
  isw_pkg::index_t out_idx_q, out_idx_d;
  logic            out_cl_q, out_cl_d;

  logic            pend_v_q, pend_v_d;
  isw_pkg::coord_t pend_lo_q, pend_lo_d;
  isw_pkg::coord_t pend_hi_q, pend_hi_d;
  isw_pkg::tag_t   pend_tag_q, pend_tag_d;
  isw_pkg::index_t pend_idx_q, pend_idx_d;

  logic            load;

  assign load        = !out_v_q || piece_o.ready;
  assign pop_ready_o = load && !pend_v_q;

  always_comb begin
    out_v_d    = out_v_q;
    out_lo_d   = out_lo_q;
    out_hi_d   = out_hi_q;
    out_tag_d  = out_tag_q;
    out_idx_d  = out_idx_q;
    out_cl_d   = out_cl_q;
    pend_v_d   = pend_v_q;
    pend_lo_d  = pend_lo_q;
    pend_hi_d  = pend_hi_q;
    pend_tag_d = pend_tag_q;
    pend_idx_d = pend_idx_q;
    if (load) begin
      out_v_d = 1'b0;
      if (pend_v_q) begin
        out_v_d   = 1'b1;
        out_lo_d  = pend_lo_q;
        out_hi_d  = pend_hi_q;
        out_tag_d = pend_tag_q;
        out_idx_d = pend_idx_q;
        out_cl_d  = 1'b1;
        pend_v_d  = 1'b0;
      end else if (pop_valid_i) begin
        out_v_d   = 1'b1;
        out_tag_d = pop_data_i.tag;
        if (pop_data_i.gap_v) begin
          out_lo_d   = pop_data_i.gap_lo;
          out_hi_d   = pop_data_i.gap_hi;
          out_idx_d  = pop_data_i.gap_idx;
          out_cl_d   = 1'b0;
          pend_v_d   = pop_data_i.rem_v;
          pend_lo_d  = pop_data_i.rem_lo;
          pend_hi_d  = pop_data_i.rem_hi;
          pend_tag_d = pop_data_i.tag;
          pend_idx_d = pop_data_i.rem_idx;
        end else begin
          out_lo_d  = pop_data_i.rem_lo;
          out_hi_d  = pop_data_i.rem_hi;
          out_idx_d = pop_data_i.rem_idx;
          out_cl_d  = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      pend_v_q <= 1'b0;
    end else begin
      out_v_q  <= out_v_d;
      pend_v_q <= pend_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_lo_q   <= out_lo_d;
    out_hi_q   <= out_hi_d;
    out_tag_q  <= out_tag_d;
    out_idx_q  <= out_idx_d;
    out_cl_q   <= out_cl_d;
    pend_lo_q  <= pend_lo_d;
    pend_hi_q  <= pend_hi_d;
    pend_tag_q <= pend_tag_d;
    pend_idx_q <= pend_idx_d;
  end

  assign piece_o.valid         = out_v_q;
  assign piece_o.piece_lo      = out_lo_q;
  assign piece_o.piece_hi      = out_hi_q;
  assign piece_o.piece_tag     = out_tag_q;
  assign piece_o.piece_index   = out_idx_q;
  assign piece_o.piece_closing = out_cl_q;

endmodule
